@@ rtl/mmbr_pkg.sv @@
// ----------------------------------------------------------------------------
// mmbr_pkg
// Types, codes and tables shared by the minimap braille rasterizer.
// ----------------------------------------------------------------------------
package mmbr_pkg;

  localparam int DIV_W = 25;  // (column + width) * dot columns
  localparam int QUO_W = 7;   // six quotient bits plus overflow

  localparam logic [1:0] CFG_BRAILLE_MODE   = 2'd0;
  localparam logic [1:0] CFG_BODY_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_VIEWPORT_WIDTH = 2'd2;

  localparam logic [7:0] DOT_BIT [4][2] = '{
    '{8'h01, 8'h08},
    '{8'h02, 8'h10},
    '{8'h04, 8'h20},
    '{8'h40, 8'h80}
  };

  typedef struct packed {
    logic        has_char;
    logic [15:0] visual_column;
    logic [7:0]  char_width;
    logic        is_ink;
    logic        line_end;
    logic        row_end;
  } item_t;

  typedef struct packed {
    logic [7:0] cell_pattern;
    logic [5:0] cell_index;
    logic       last_cell;
  } cell_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_DIV_LO,
    ST_MUL_HI,
    ST_DIV_HI,
    ST_MASK,
    ST_LINE,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] braille_cell(input logic [3:0][1:0] dots);
    logic [7:0] pat;
    pat = '0;
    for (int py = 0; py < 4; py++) begin
      for (int px = 0; px < 2; px++) begin
        if (dots[py][px]) pat = pat | DOT_BIT[py][px];
      end
    end
    return pat;
  endfunction

endpackage

@@ rtl/mmbr_div.sv @@
// ----------------------------------------------------------------------------
// mmbr_div
// Restoring divider, one compare-subtract per cycle, bit 6 flags quotients >= 64.
// ----------------------------------------------------------------------------
module mmbr_div
  import mmbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [15:0]      divisor,
  output div_status_t      status
);

  logic [DIV_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [2:0]       k;
  logic             busy;
  logic             done;
  logic [DIV_W-1:0] dsh;
  logic             ge;

  // bit 6 of the quotient flags any quotient of 64 or more
  assign dsh = {{(DIV_W-16){1'b0}}, divisor} << k;
  assign ge  = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      quo <= '0;
      k   <= 3'(QUO_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem    <= rem - dsh;
        quo[k] <= 1'b1;
      end
      k <= k - 3'd1;
    end
  end

  assign status.done = done;
  assign status.quo  = quo;

endmodule

@@ rtl/text_minimap_braille_rasterizer.sv @@
// ----------------------------------------------------------------------------
// text_minimap_braille_rasterizer
// Marks character dot spans per line and emits minimap cells per row.
// ----------------------------------------------------------------------------
// Ink character: multiply, then two passes of the shared divider (7 steps plus
//   done), mask and line steps; the second pass and the mask step are skipped
//   when column and width are both zero. Other items take only the line step.
// A completed row emits min(body_width, 64) cells, one per cycle unless stalled.
// One item in flight; the next item is taken while the last cell waits.
// Synchronous reset restores config defaults and clears masks and counts.
module text_minimap_braille_rasterizer
  import mmbr_pkg::*;
#(
  parameter int DOT_MASK_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        cell_valid,
  input  logic        cell_stall,
  output cell_t       cell_data
);

  localparam logic [5:0] LIM = 6'(DOT_MASK_BITS - 1);

  logic        braille_mode;
  logic [6:0]  body_width;
  logic [15:0] viewport_width;

  state_t state, state_next;
  item_t  item_r;

  logic [DOT_MASK_BITS-1:0] line_dot_mask;
  logic [DOT_MASK_BITS-1:0] row_masks [4];
  logic [1:0]               lines_in_row;
  logic [5:0]               cnt;
  logic [QUO_W-1:0]         start_q;
  logic [QUO_W-1:0]         end_q;

  logic [6:0]       bw_eff;
  logic [7:0]       dot_cols;
  logic [15:0]      vp_eff;
  logic [16:0]      col_sum;
  logic [16:0]      mul_a;
  logic [DIV_W-1:0] prod;
  logic [DIV_W-1:0] dividend;
  logic             div_start;
  div_status_t      div_st;

  logic       slot_free;
  logic       cell_load;
  logic       last;
  logic       emit_row;
  logic       emit_done;
  logic [5:0] end_c;
  logic       do_set;
  logic [DOT_MASK_BITS-1:0] span;
  logic [3:0][1:0]          dots;

  always_ff @(posedge clk) begin
    if (rst) begin
      braille_mode   <= 1'b1;
      body_width     <= 7'd32;
      viewport_width <= 16'd80;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BRAILLE_MODE:   braille_mode   <= cfg_data[0];
        CFG_BODY_WIDTH:     body_width     <= cfg_data[6:0];
        CFG_VIEWPORT_WIDTH: viewport_width <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bw_eff   = (body_width > 7'd64) ? 7'd64 : body_width;
  assign dot_cols = (bw_eff == 7'd0) ? 8'd1 :
                    braille_mode ? {bw_eff, 1'b0} : {1'b0, bw_eff};
  assign vp_eff   = (viewport_width == 16'd0) ? 16'd1 : viewport_width;

  assign col_sum  = {1'b0, item_r.visual_column} + {9'd0, item_r.char_width};
  assign mul_a    = (state == ST_MUL_HI) ? col_sum : {1'b0, item_r.visual_column};
  assign prod     = DIV_W'(mul_a) * DIV_W'(dot_cols);
  assign dividend = (state == ST_MUL_HI) ? prod - DIV_W'(1) : prod;

  mmbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (vp_eff),
    .status   (div_st)
  );

  assign slot_free = !cell_valid || !cell_stall;
  assign last      = ({1'b0, cnt} + 7'd1) == bw_eff;
  assign emit_row  = item_r.line_end &&
                     (!braille_mode || lines_in_row == 2'd3 || item_r.row_end);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (item_valid) state_next = (item.has_char && item.is_ink) ?
                                              ST_MUL_LO : ST_LINE;
      ST_MUL_LO: state_next = ST_DIV_LO;
      ST_DIV_LO: if (div_st.done) state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = (col_sum == 17'd0) ? ST_LINE : ST_DIV_HI;
      ST_DIV_HI: if (div_st.done) state_next = ST_MASK;
      ST_MASK:   state_next = ST_LINE;
      ST_LINE:   state_next = emit_row ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (emit_done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    div_start  = 1'b0;
    cell_load  = 1'b0;
    emit_done  = 1'b0;
    case (state)
      ST_IDLE:   item_stall = 1'b0;
      ST_MUL_LO: div_start  = 1'b1;
      ST_MUL_HI: div_start  = col_sum != 17'd0;
      ST_EMIT: begin
        cell_load = slot_free && bw_eff != 7'd0;
        emit_done = bw_eff == 7'd0 || (slot_free && last);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) item_r <= item;
    if (state == ST_DIV_LO && div_st.done) start_q <= div_st.quo;
    if (state == ST_DIV_HI && div_st.done) end_q <= div_st.quo;
  end

  // dot span for the character
  assign end_c  = (end_q[QUO_W-1] || end_q[5:0] > LIM) ? LIM : end_q[5:0];
  assign do_set = !start_q[QUO_W-1] && start_q[5:0] <= end_c;
  assign span   = ({DOT_MASK_BITS{1'b1}} >> (LIM - end_c)) &
                  ({DOT_MASK_BITS{1'b1}} << start_q[5:0]);

  always_comb begin
    for (int py = 0; py < 4; py++) dots[py] = row_masks[py][1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_dot_mask <= '0;
      lines_in_row  <= '0;
      cnt           <= '0;
      for (int i = 0; i < 4; i++) row_masks[i] <= '0;
    end else begin
      case (state)
        ST_MASK: if (do_set) line_dot_mask <= line_dot_mask | span;
        ST_LINE: begin
          cnt <= '0;
          if (item_r.line_end) begin
            line_dot_mask <= '0;
            if (!braille_mode) begin
              row_masks[0] <= line_dot_mask;
              for (int i = 1; i < 4; i++) row_masks[i] <= '0;
              lines_in_row <= '0;
            end else begin
              row_masks[lines_in_row] <= line_dot_mask;
              lines_in_row <= emit_row ? 2'd0 : lines_in_row + 2'd1;
            end
          end
        end
        ST_EMIT: begin
          if (emit_done) begin
            for (int i = 0; i < 4; i++) row_masks[i] <= '0;
          end else if (cell_load) begin
            cnt <= cnt + 6'd1;
            for (int i = 0; i < 4; i++) begin
              row_masks[i] <= braille_mode ? row_masks[i] >> 2 : row_masks[i] >> 1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cell_valid <= 1'b0;
    else if (cell_load) cell_valid <= 1'b1;
    else if (!cell_stall) cell_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cell_load) begin
      cell_data.cell_pattern <= braille_mode ? braille_cell(dots) :
                                               {7'd0, row_masks[0][0]};
      cell_data.cell_index   <= cnt;
      cell_data.last_cell    <= last;
    end
  end

  a_lines_only_on_line: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LINE) |=> $stable(lines_in_row))
    else $error("row line count changed outside line close");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DIV_LO || state == ST_DIV_HI))
    else $error("divider finished outside a divide step");

  a_rows_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && emit_done) |=>
      (row_masks[0] == '0 && row_masks[1] == '0 &&
       row_masks[2] == '0 && row_masks[3] == '0))
    else $error("row masks not cleared after emission");

  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    cell_load |-> ({1'b0, cnt} < bw_eff))
    else $error("cell index beyond body width");

endmodule

@@ sim/tb_text_minimap_braille_rasterizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_minimap_braille_rasterizer
// Self-checking bench for the minimap braille rasterizer. A directed part
// covers the edge cases of the dot span maths: zero widths, spans past the
// mask, whitespace, row and line end combinations, a mode change mid-row and
// extreme register values. A random part follows with well-formed text lines
// and some noise under several register settings. A predictor in the bench
// keeps its own line and row masks and queues the cells each item should
// produce; the monitor checks every cell against the oldest one queued.
// ----------------------------------------------------------------------------
module tb_text_minimap_braille_rasterizer;
  import mmbr_pkg::*;

  localparam int SETTLE      = 40;
  localparam int QUIET_LIMIT = 1000;

  localparam logic [7:0] DOT_WEIGHT [4][2] = '{
    '{8'h01, 8'h08}, '{8'h02, 8'h10}, '{8'h04, 8'h20}, '{8'h40, 8'h80}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_BRAILLE_MODE;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        cell_valid;
  logic        cell_stall = 1'b0;
  cell_t       cell_data;

  text_minimap_braille_rasterizer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_data  (cell_data)
  );

  always #10 clk = ~clk;

  wire item_taken = item_valid && !item_stall;
  wire cell_taken = cell_valid && !cell_stall;

  // predictor state
  bit          m_braille;
  logic [6:0]  m_body;
  logic [15:0] m_view;
  logic [63:0] line_mask;
  logic [63:0] row_masks [4];
  int          lines_held;

  item_t items_todo [$];
  cell_t cells_due [$];

  int items_queued, items_done, cells_seen, rows_seen, settings_run, errors;
  int gap_left, calm_in, hold_left, calm_out, out_wait;
  cell_t want;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // zero wait for a stretch now and then, otherwise a random wait
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic predict_cells(input item_t it);
    logic [63:0] n, v, hi, lo_dot, hi_dot;
    int   bw, x, py, px, dc;
    bit   emit;
    logic [7:0] pat;
    cell_t c;
    bw = (m_body > 7'd64) ? 64 : int'(m_body);
    if (it.has_char && it.is_ink) begin
      n = m_braille ? 64'(2 * bw) : 64'(bw);
      if (n == 64'd0) n = 64'd1;
      v = (m_view == 16'd0) ? 64'd1 : 64'(m_view);
      hi = (64'(it.visual_column) + 64'(it.char_width)) * n;
      if (hi != 64'd0) begin
        lo_dot = 64'(it.visual_column) * n / v;
        hi_dot = (hi - 64'd1) / v;
        if (hi_dot > 64'd63) hi_dot = 64'd63;
        if (lo_dot <= hi_dot)
          line_mask |= ({64{1'b1}} >> (64'd63 - hi_dot)) & ~((64'd1 << lo_dot) - 64'd1);
      end
    end
    if (!it.line_end) return;
    if (!m_braille) begin
      row_masks[0] = line_mask;
      row_masks[1] = '0;
      row_masks[2] = '0;
      row_masks[3] = '0;
      lines_held = 1;
      emit = 1'b1;
    end else begin
      if (lines_held < 4) begin
        row_masks[lines_held] = line_mask;
        lines_held++;
      end
      emit = (lines_held >= 4) || it.row_end;
    end
    line_mask = '0;
    if (!emit) return;
    for (x = 0; x < bw; x++) begin
      pat = '0;
      if (m_braille) begin
        for (py = 0; py < 4 && py < lines_held; py++) begin
          for (px = 0; px < 2; px++) begin
            dc = 2 * x + px;
            if (dc < 64 && row_masks[py][dc]) pat |= DOT_WEIGHT[py][px];
          end
        end
      end else if (lines_held > 0 && row_masks[0][x]) begin
        pat = 8'd1;
      end
      c.cell_pattern = pat;
      c.cell_index   = x[5:0];
      c.last_cell    = (x + 1 == bw);
      cells_due.insert(cells_due.size(), c);
    end
    for (py = 0; py < 4; py++) row_masks[py] = '0;
    lines_held = 0;
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_taken) begin
        predict_cells(item);
        items_done++;
      end
      if (!item_valid || item_taken) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (items_todo.size() != 0) begin
          item       <= items_todo.pop_front();
          item_valid <= 1'b1;
          gap_left   <= draw_wait(calm_in);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // cell monitor
  always @(posedge clk) begin
    if (rst) begin
      cell_stall <= 1'b0;
      hold_left  <= 0;
    end else if (cell_taken) begin
      if (cells_due.size() == 0) begin
        report_mismatch($sformatf("unexpected cell idx %0d pattern %02h last %0b",
                                  cell_data.cell_index, cell_data.cell_pattern,
                                  cell_data.last_cell));
      end else begin
        want = cells_due.pop_front();
        if (cell_data.cell_pattern !== want.cell_pattern)
          report_mismatch($sformatf("cell %0d pattern %02h, want %02h",
                                    want.cell_index, cell_data.cell_pattern,
                                    want.cell_pattern));
        if (cell_data.cell_index !== want.cell_index)
          report_mismatch($sformatf("cell index %0d, want %0d",
                                    cell_data.cell_index, want.cell_index));
        if (cell_data.last_cell !== want.last_cell)
          report_mismatch($sformatf("cell %0d last %0b, want %0b",
                                    want.cell_index, cell_data.last_cell, want.last_cell));
      end
      cells_seen++;
      if (cell_data.last_cell) rows_seen++;
      out_wait = draw_wait(calm_out);
      hold_left  <= out_wait;
      cell_stall <= (out_wait != 0);
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      cell_stall <= (hold_left > 1);
    end
  end

  // watchdog
  int quiet;
  always @(posedge clk) begin
    if (rst || item_taken || cell_taken) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no item or cell moved for %0d cycles", QUIET_LIMIT);
        $display("** text_minimap_braille_rasterizer: FAILED **");
        $finish;
      end
    end
  end

  task automatic queue_item(input bit has, input logic [15:0] col, input logic [7:0] wid,
                            input bit ink, input bit le, input bit re);
    item_t it;
    it.has_char      = has;
    it.visual_column = col;
    it.char_width    = wid;
    it.is_ink        = ink;
    it.line_end      = le;
    it.row_end       = re;
    items_todo.insert(items_todo.size(), it);
    items_queued++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (items_todo.size() != 0 || item_valid || cells_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_BRAILLE_MODE:   m_braille = val[0];
      CFG_BODY_WIDTH:     m_body    = val[6:0];
      CFG_VIEWPORT_WIDTH: m_view    = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input bit mode, input int body, input int view);
    drain();
    set_reg(CFG_BRAILLE_MODE, 16'(mode));
    set_reg(CFG_BODY_WIDTH, 16'(body));
    set_reg(CFG_VIEWPORT_WIDTH, 16'(view));
    settings_run++;
    @(negedge clk);
  endtask

  // a text line: characters mostly left to right, closed by a line end
  task automatic queue_text_line(input int vw);
    int nch, col, w, k;
    bit end_on_char, re;
    nch = $urandom_range(0, 6);
    col = $urandom_range(0, 6);
    end_on_char = (nch != 0) && ($urandom_range(0, 1) == 1);
    re = ($urandom_range(0, 3) == 0);
    for (k = 0; k < nch; k++) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 255);
        1, 2:    w = $urandom_range(2, 8);
        default: w = 1;
      endcase
      if ($urandom_range(0, 5) == 0) col = $urandom_range(0, vw + vw / 8);
      if (col > 65535) col = 65535;
      queue_item(1'b1, col[15:0], w[7:0], $urandom_range(0, 4) != 0,
                 end_on_char && (k == nch - 1), re);
      col += w + $urandom_range(0, 3);
    end
    if (!end_on_char) queue_item(1'b0, 16'($urandom), 8'($urandom), 1'($urandom), 1'b1, re);
  endtask

  initial begin
    int ph, target, body, view;
    m_braille  = 1'b1;
    m_body     = 7'd32;
    m_view     = 16'd80;
    line_mask  = '0;
    for (int i = 0; i < 4; i++) row_masks[i] = '0;
    lines_held = 0;
    calm_in    = 0;
    calm_out   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: braille, 32 cells, 80 columns
    queue_item(1'b1, 16'd0, 8'd1, 1'b1, 1'b0, 1'b0);
    queue_item(1'b1, 16'd79, 8'd1, 1'b1, 1'b0, 1'b0);
    queue_item(1'b1, 16'd0, 8'd0, 1'b1, 1'b0, 1'b0);
    queue_item(1'b1, 16'd5, 8'd0, 1'b1, 1'b0, 1'b0);
    queue_item(1'b1, 16'd20, 8'd8, 1'b0, 1'b0, 1'b0);
    queue_item(1'b0, 16'd30, 8'd4, 1'b1, 1'b0, 1'b0);
    queue_item(1'b1, 16'd40, 8'd2, 1'b1, 1'b1, 1'b1);
    queue_item(1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0);
    queue_item(1'b1, 16'd10, 8'hFF, 1'b1, 1'b0, 1'b1);
    queue_item(1'b0, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0);
    queue_item(1'b1, 16'd3, 8'd1, 1'b1, 1'b1, 1'b0);
    queue_item(1'b1, 16'd60, 8'd10, 1'b1, 1'b1, 1'b0);
    queue_item(1'b1, 16'd0, 8'd80, 1'b1, 1'b1, 1'b0);
    // two lines held, then block mode drops them
    queue_item(1'b1, 16'd7, 8'd3, 1'b1, 1'b1, 1'b0);
    queue_item(1'b1, 16'd50, 8'd2, 1'b1, 1'b1, 1'b0);
    settings_run = 1;
    configure(1'b0, 32, 80);
    queue_item(1'b1, 16'd12, 8'd5, 1'b1, 1'b1, 1'b0);
    configure(1'b0, 64, 64);
    queue_item(1'b1, 16'd0, 8'd64, 1'b1, 1'b1, 1'b0);
    configure(1'b1, 0, 1);
    queue_item(1'b1, 16'd3, 8'd1, 1'b1, 1'b1, 1'b1);
    configure(1'b1, 127, 1);
    queue_item(1'b1, 16'd2, 8'd1, 1'b1, 1'b1, 1'b1);
    configure(1'b1, 64, 0);
    queue_item(1'b1, 16'd1, 8'd1, 1'b1, 1'b1, 1'b1);
    configure(1'b1, 64, 65535);
    queue_item(1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0);
    queue_item(1'b1, 16'd0, 8'hFF, 1'b1, 1'b1, 1'b1);
    configure(1'b0, 1, 1);
    queue_item(1'b1, 16'd0, 8'd1, 1'b1, 1'b1, 1'b0);

    for (ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0:       body = 64;
        1:       body = $urandom_range(65, 127);
        default: body = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 5))
        0:       view = $urandom_range(1, 3);
        1:       view = $urandom_range(256, 65535);
        default: view = $urandom_range(8, 120);
      endcase
      configure(1'($urandom_range(0, 1)), body, view);
      target = items_queued + 14;
      while (items_queued < target) begin
        if ($urandom_range(0, 7) == 0)
          queue_item(1'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                     1'($urandom), 1'($urandom));
        else
          queue_text_line(view);
      end
    end

    drain();
    $display("Covered %0d items and %0d cells in %0d rows over %0d register settings,",
             items_done, cells_seen, rows_seen, settings_run);
    $display("both modes, body widths 0 to 127 and viewports 0 to 65535; %0d errors.", errors);
    if (errors == 0) begin
      $display("** text_minimap_braille_rasterizer: PASSED **");
    end else begin
      $display("** text_minimap_braille_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
